// ----- sv/csvt_pkg.sv -----
// csvt_pkg: shared types, constants and helpers for the CSV byte tokenizer.
// No dependencies.
`default_nettype none
package csvt_pkg;

    localparam int unsigned DelimW   = 7;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned KindW    = 2;
    localparam int unsigned MaxRes   = 3;
    localparam int unsigned CntW     = 2;

    localparam logic [DelimW-1:0] DelimReset = 7'd44;

    localparam logic [ByteW-1:0] ByteCr    = 8'h0D;
    localparam logic [ByteW-1:0] ByteLf    = 8'h0A;
    localparam logic [ByteW-1:0] ByteQuote = 8'h22;

    localparam logic [1:0] BomDone = 2'd3;

    localparam logic OpData = 1'b0;
    localparam logic OpEnd  = 1'b1;

    localparam logic [KindW-1:0] KindChar   = 2'd0;
    localparam logic [KindW-1:0] KindField  = 2'd1;
    localparam logic [KindW-1:0] KindRecord = 2'd2;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] char_value;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0]          cnt;
        t_result [MaxRes-1:0]     res;
    } t_step;

    typedef struct packed {
        logic [1:0] bom_position;
        logic       in_quotes;
        logic       quote_pending;
        logic       line_nonempty;
    } t_state;

    function automatic logic [ByteW-1:0] bom_byte(input logic [1:0] pos);
        logic [ByteW-1:0] b;
        case (pos)
            2'd0:    b = 8'hEF;
            2'd1:    b = 8'hBB;
            2'd2:    b = 8'hBF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- sv/csvt_in_if.sv -----
// csvt_in_if: input beat channel (opcode, data byte) with valid/ready.
// Depends on nothing.
`default_nettype none
interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/csvt_out_if.sv -----
// csvt_out_if: result beat channel (kind, char_value, last_of_run) with valid/ready.
// Depends on nothing.
`default_nettype none
interface csvt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_value;
    logic       last_of_run;

    modport source (output valid, output kind, output char_value, output last_of_run,
                    input ready);
    modport sink   (input valid, input kind, input char_value, input last_of_run,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/csv_byte_tokenizer.sv -----
// csv_byte_tokenizer: streaming CSV tokenizer, one input beat per cycle if not held.
// A beat's first result is registered, valid the cycle after the beat is accepted.
// Throughput: one beat per cycle while each beat yields at most one result and the
// output is ready; a beat yielding n results holds the input while they drain.
// Reset (i_rst_n low, synchronous): delimiter back to comma, tokenizer state cleared,
// result register emptied.
`default_nettype none
module csv_byte_tokenizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_data,
    csvt_in_if.sink         i_in,
    csvt_out_if.source      o_out
);
    import csvt_pkg::*;

    logic [DelimW-1:0] r_delimiter;
    t_state            r_state;
    t_state            n_state;
    t_step             step;
    logic              space;
    logic              accept;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    csvt_decode u_decode (
        .i_state     (r_state),
        .i_delimiter (r_delimiter),
        .i_opcode    (i_in.opcode),
        .i_data_byte (i_in.data_byte),
        .o_step      (step),
        .o_state     (n_state)
    );

    csvt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_step  (step),
        .o_space (space),
        .o_out   (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter <= DelimReset;
            r_state     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_delimiter <= i_cfg_data;
            end
            if (accept) begin
                r_state <= n_state;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/csvt_decode.sv -----
// csvt_decode: per-beat tokenizer logic; builds up to three results and next state.
// Depends on csvt_pkg.
`default_nettype none
module csvt_decode (
    input  wire csvt_pkg::t_state          i_state,
    input  wire logic [6:0]                i_delimiter,
    input  wire logic                      i_opcode,
    input  wire logic [7:0]                i_data_byte,
    output csvt_pkg::t_step                o_step,
    output csvt_pkg::t_state               o_state
);
    import csvt_pkg::*;

    logic       bom_active;
    logic       bom_match;
    logic [1:0] held;
    logic       lnz;
    logic       ev_valid;
    t_result    ev;
    t_state     ns;

    always_comb begin
        bom_active = (i_state.bom_position != BomDone);
        bom_match  = bom_active && (i_opcode == OpData)
                     && (i_data_byte == bom_byte(i_state.bom_position));
        held       = (bom_active && !bom_match) ? i_state.bom_position : 2'd0;
        lnz        = i_state.line_nonempty | (held != 2'd0);

        ns                = i_state;
        ns.line_nonempty  = lnz;
        ev_valid          = 1'b0;
        ev.kind           = KindChar;
        ev.char_value     = i_data_byte;

        if (i_opcode == OpEnd) begin
            ev_valid      = lnz;
            ev.kind       = KindRecord;
            ev.char_value = '0;
            ns            = '0;
        end else if (bom_match) begin
            ns.bom_position = i_state.bom_position + 2'd1;
        end else begin
            ns.bom_position = BomDone;
            if (i_data_byte == ByteCr) begin
                ev_valid = 1'b0;
            end else if (i_data_byte == ByteLf) begin
                ev_valid          = lnz;
                ev.kind           = KindRecord;
                ev.char_value     = '0;
                ns.in_quotes      = 1'b0;
                ns.quote_pending  = 1'b0;
                ns.line_nonempty  = 1'b0;
            end else begin
                ns.line_nonempty = 1'b1;
                if (i_state.in_quotes && !i_state.quote_pending) begin
                    if (i_data_byte == ByteQuote) begin
                        ns.quote_pending = 1'b1;
                    end else begin
                        ev_valid = 1'b1;
                    end
                end else if (i_state.in_quotes && (i_data_byte == ByteQuote)) begin
                    // doubled quote
                    ns.quote_pending = 1'b0;
                    ev_valid         = 1'b1;
                end else begin
                    ns.quote_pending = 1'b0;
                    ns.in_quotes     = 1'b0;
                    if (i_data_byte == ByteQuote) begin
                        ns.in_quotes = 1'b1;
                    end else if (i_data_byte == {1'b0, i_delimiter}) begin
                        ev_valid      = 1'b1;
                        ev.kind       = KindField;
                        ev.char_value = '0;
                    end else begin
                        ev_valid = 1'b1;
                    end
                end
            end
        end

        o_step.cnt = held + {1'b0, ev_valid};
        for (int i = 0; i < MaxRes; i++) begin
            if (CntW'(i) < held) begin
                o_step.res[i].kind       = KindChar;
                o_step.res[i].char_value = bom_byte(CntW'(i));
            end else begin
                o_step.res[i] = ev;
            end
        end
        o_state = ns;
    end

endmodule
`default_nettype wire

// ----- sv/csvt_outq.sv -----
// csvt_outq: result register holding one beat's run of up to three results.
// Depends on csvt_pkg and csvt_out_if.
`default_nettype none
module csvt_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire csvt_pkg::t_step   i_step,
    output logic                   o_space,
    csvt_out_if.source             o_out
);
    import csvt_pkg::*;

    logic [CntW-1:0]       r_cnt;
    t_result [MaxRes-1:0]  r_res;
    logic                  fire;

    assign fire    = o_out.valid && o_out.ready;
    assign o_space = (r_cnt == '0) || ((r_cnt == CntW'(1)) && o_out.ready);

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.kind        = r_res[0].kind;
    assign o_out.char_value  = r_res[0].char_value;
    assign o_out.last_of_run = (r_cnt == CntW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_step.cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_step.res;
        end else if (fire) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule
`default_nettype wire
